FILE: design/star_polygon_point_hit_test_assert.svh
// Assertion macros for the star polygon hit test
`ifndef STAR_POLYGON_POINT_HIT_TEST_ASSERT_SVH
`define STAR_POLYGON_POINT_HIT_TEST_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define SPH_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies a consequence in the next cycle
`define SPH_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/sph_pkg.sv
// Package: types, codes and constants for the star polygon hit test
package sph_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_TEST  = 2'd1,
    OP_MOVE  = 2'd2,
    OP_SET   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    DEC_OUTER = 2'd0,
    DEC_INNER = 2'd1,
    DEC_FAN   = 2'd2
  } dec_t;

  typedef enum logic [1:0] {
    REG_VCOUNT = 2'd0,
    REG_INNER  = 2'd1,
    REG_OUTER  = 2'd2,
    REG_TOL    = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_RADIUS,
    ST_LOAD,
    ST_WALK,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         vertex_index;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } in_beat_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] decided_by;
  } out_beat_t;

  // Control handed from the sequencer to the cell row
  typedef struct packed {
    logic load;
    logic shift;
  } row_ctl_t;

endpackage

FILE: design/sph_cell.sv
// One ring cell: holds a vertex pair and hands it to its neighbor while the walk runs
module sph_cell (
  input  logic                clk,
  input  sph_pkg::row_ctl_t   ctl,
  input  logic signed [15:0]  load_x,
  input  logic signed [15:0]  load_y,
  input  logic signed [15:0]  prev_x,
  input  logic signed [15:0]  prev_y,
  output logic signed [15:0]  vx,
  output logic signed [15:0]  vy
);

  logic signed [15:0] vx_r, vy_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      vx_r <= load_x;
      vy_r <= load_y;
    end else if (ctl.shift) begin
      vx_r <= prev_x;
      vy_r <= prev_y;
    end
  end

  assign vx = vx_r;
  assign vy = vy_r;

endmodule

FILE: design/sph_fan.sv
// Fan triangle test unit: bounding box and doubled area check, pipelined
module sph_fan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] bx,
  input  logic signed [15:0] by,
  input  logic signed [15:0] cx,
  input  logic signed [15:0] cy,
  input  logic signed [15:0] px,
  input  logic signed [15:0] py,
  input  logic [15:0]        tol,
  output logic               hit
);

  // offsets from center; absolute vertex is center + offset (17 bits)
  logic signed [17:0] aax, aay, abx, aby;
  logic signed [17:0] dbx, dby, dcx, dcy, dpx, dpy;
  logic               box_ok;
  logic signed [36:0] m0a, m0b, m1a, m1b, m2a, m2b, m3a, m3b;
  logic signed [36:0] m0a_r, m0b_r, m1a_r, m1b_r, m2a_r, m2b_r, m3a_r, m3b_r;
  logic               v1_r, box1_r, v2_r;
  logic [15:0]        tol1_r;
  logic signed [37:0] c0, c1, c2, c3;
  logic [37:0]        a0, a1, a2, a3;
  logic [39:0]        whole_r, parts_r;
  logic [15:0]        tol2_r;
  logic [39:0]        diff;
  logic               hit_r;

  always_comb begin
    logic signed [17:0] mnx, mxx, mny, mxy;
    aax = 18'(cx) + 18'(ax);
    aay = 18'(cy) + 18'(ay);
    abx = 18'(cx) + 18'(bx);
    aby = 18'(cy) + 18'(by);
    mnx = (aax < abx) ? aax : abx;
    mnx = (mnx < 18'(cx)) ? mnx : 18'(cx);
    mxx = (aax > abx) ? aax : abx;
    mxx = (mxx > 18'(cx)) ? mxx : 18'(cx);
    mny = (aay < aby) ? aay : aby;
    mny = (mny < 18'(cy)) ? mny : 18'(cy);
    mxy = (aay > aby) ? aay : aby;
    mxy = (mxy > 18'(cy)) ? mxy : 18'(cy);
    box_ok = !(18'(px) < mnx || 18'(px) > mxx || 18'(py) < mny || 18'(py) > mxy);
    // relative to a
    dbx = abx - aax;
    dby = aby - aay;
    dcx = 18'(cx) - aax;
    dcy = 18'(cy) - aay;
    dpx = 18'(px) - aax;
    dpy = 18'(py) - aay;
    // whole: b x c; abp: b x p; acp: c x p relative to a; bcp via c,b from p
    m0a = 37'(dbx) * 37'(dcy);
    m0b = 37'(dby) * 37'(dcx);
    m1a = 37'(dbx) * 37'(dpy);
    m1b = 37'(dby) * 37'(dpx);
    m2a = 37'(dcx) * 37'(dpy);
    m2b = 37'(dcy) * 37'(dpx);
    // b-p, c-p
    m3a = 37'(abx - 18'(px)) * 37'(18'(cy) - 18'(py));
    m3b = 37'(aby - 18'(py)) * 37'(18'(cx) - 18'(px));
  end

  always_ff @(posedge clk) begin
    m0a_r <= m0a; m0b_r <= m0b; m1a_r <= m1a; m1b_r <= m1b;
    m2a_r <= m2a; m2b_r <= m2b; m3a_r <= m3a; m3b_r <= m3b;
    box1_r <= box_ok;
    tol1_r <= tol;
  end

  always_comb begin
    c0 = 38'(m0a_r) - 38'(m0b_r);
    c1 = 38'(m1a_r) - 38'(m1b_r);
    c2 = 38'(m2a_r) - 38'(m2b_r);
    c3 = 38'(m3a_r) - 38'(m3b_r);
    a0 = c0[37] ? 38'(-c0) : 38'(c0);
    a1 = c1[37] ? 38'(-c1) : 38'(c1);
    a2 = c2[37] ? 38'(-c2) : 38'(c2);
    a3 = c3[37] ? 38'(-c3) : 38'(c3);
  end

  always_ff @(posedge clk) begin
    whole_r <= 40'(a0);
    parts_r <= 40'(a1) + 40'(a2) + 40'(a3);
    tol2_r  <= box1_r ? tol1_r : 16'd0;
  end

  assign diff = (whole_r > parts_r) ? (whole_r - parts_r) : (parts_r - whole_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      v1_r  <= valid;
      v2_r  <= v1_r;
      hit_r <= v2_r && (diff < 40'(tol2_r));
    end
  end

  assign hit = hit_r;

endmodule

FILE: design/star_polygon_point_hit_test.sv
// Star polygon hit test: a point test is decided by a radius or needs the triangle walk,
// n vertices in use; write, move and set-center beats give no result. A new beat is
// accepted only while busy is low, after the previous one is through. A test
// computes the squared distance, compares it with the radii, then loads the
// vertex offsets into a ring of cells that rotates one place per cycle,
// feeding one fan triangle per cycle into a three-stage area unit, and the
// pipeline drains after the walk of n triangles. The result strobe out_valid
// is high for one cycle; the receiver cannot stall.
`include "star_polygon_point_hit_test_assert.svh"
module star_polygon_point_hit_test #(
  parameter int MAX_VERTICES = sph_pkg::MAX_VERTICES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sph_pkg::in_beat_t in_beat,
  output logic              out_valid,
  output sph_pkg::out_beat_t out_beat,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  sph_pkg::state_t state_r, state_nxt;

  logic [4:0]  vcount_r;
  logic [31:0] inner_r, outer_r;
  logic [15:0] tol_r;

  logic signed [15:0] vtx_x [MAX_VERTICES];
  logic signed [15:0] vtx_y [MAX_VERTICES];
  logic signed [15:0] cx_r, cy_r, px_r, py_r;
  logic [34:0]        d2_r;
  logic [CW-1:0]      n_r, cnt_r, cnt_nxt;
  logic [2:0]         drain_r, drain_nxt;
  logic               hit_acc_r, hit_acc_nxt;
  logic               ov_r, ov_nxt;
  sph_pkg::out_beat_t ob_r, ob_nxt;

  logic               wr_en;
  logic [1:0]         widx;
  logic               acc;
  sph_pkg::row_ctl_t  ctl;
  logic               fan_valid, fan_hit;

  logic signed [15:0] cell_x [MAX_VERTICES];
  logic signed [15:0] cell_y [MAX_VERTICES];
  logic signed [15:0] first_x, first_y;

  assign pready = 1'b1;
  assign widx   = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign acc    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 5'd8;
      inner_r  <= 32'd0;
      outer_r  <= 32'd0;
      tol_r    <= 16'd1;
    end else if (wr_en) begin
      unique case (sph_pkg::reg_t'(widx))
        sph_pkg::REG_VCOUNT: vcount_r <= pwdata[4:0];
        sph_pkg::REG_INNER:  inner_r  <= pwdata;
        sph_pkg::REG_OUTER:  outer_r  <= pwdata;
        sph_pkg::REG_TOL:    tol_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sph_pkg::reg_t'(widx))
      sph_pkg::REG_VCOUNT: prdata = 32'(vcount_r);
      sph_pkg::REG_INNER:  prdata = inner_r;
      sph_pkg::REG_OUTER:  prdata = outer_r;
      sph_pkg::REG_TOL:    prdata = 32'(tol_r);
      default:             prdata = 32'd0;
    endcase
  end

  // vertex store and center
  always_ff @(posedge clk) begin
    if (acc && sph_pkg::op_t'(in_beat.operation) == sph_pkg::OP_WRITE &&
        32'(in_beat.vertex_index) < MAX_VERTICES) begin
      vtx_x[IW'(in_beat.vertex_index)] <= in_beat.coord_x;
      vtx_y[IW'(in_beat.vertex_index)] <= in_beat.coord_y;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= 16'sd0;
      cy_r <= 16'sd0;
    end else if (acc && sph_pkg::op_t'(in_beat.operation) == sph_pkg::OP_MOVE) begin
      cx_r <= cx_r + in_beat.coord_x;
      cy_r <= cy_r + in_beat.coord_y;
    end else if (acc && sph_pkg::op_t'(in_beat.operation) == sph_pkg::OP_SET) begin
      cx_r <= in_beat.coord_x;
      cy_r <= in_beat.coord_y;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [16:0] ddx, ddy;
    ddx = 17'(px_r) - 17'(cx_r);
    ddy = 17'(py_r) - 17'(cy_r);
    if (acc) begin
      px_r <= in_beat.coord_x;
      py_r <= in_beat.coord_y;
      if (vcount_r < 5'd3) n_r <= CW'(3);
      else if (32'(vcount_r) > MAX_VERTICES) n_r <= CW'(MAX_VERTICES);
      else n_r <= CW'(vcount_r);
    end
    if (state_r == sph_pkg::ST_DIST)
      d2_r <= 35'(34'(ddx * ddx)) + 35'(34'(ddy * ddy));
  end

  // ring of cells: cell k loads vertex k, then takes its neighbor's pair
  genvar k;
  generate
    for (k = 0; k < MAX_VERTICES; k++) begin : g_cell
      logic signed [15:0] nx, ny;
      if (k == MAX_VERTICES - 1) begin : g_last
        assign nx = first_x;
        assign ny = first_y;
      end else begin : g_mid
        assign nx = cell_x[k+1];
        assign ny = cell_y[k+1];
      end
      sph_cell u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .load_x (vtx_x[k]),
        .load_y (vtx_y[k]),
        .prev_x (nx),
        .prev_y (ny),
        .vx     (cell_x[k]),
        .vy     (cell_y[k])
      );
    end
  endgenerate

  // first vertex kept aside so the ring wraps at n, not at the full depth
  logic signed [15:0] v0x_r, v0y_r;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      v0x_r <= vtx_x[0];
      v0y_r <= vtx_y[0];
    end
  end
  assign first_x = v0x_r;
  assign first_y = v0y_r;

  // second vertex of triangle i: cell 1, or vertex 0 on the last triangle
  logic signed [15:0] bx, by;
  assign bx = (cnt_r == n_r - CW'(1)) ? v0x_r : cell_x[1];
  assign by = (cnt_r == n_r - CW'(1)) ? v0y_r : cell_y[1];
  assign fan_valid = (state_r == sph_pkg::ST_WALK);

  sph_fan u_fan (
    .clk   (clk),
    .rst_n (rst_n),
    .valid (fan_valid),
    .ax    (cell_x[0]),
    .ay    (cell_y[0]),
    .bx    (bx),
    .by    (by),
    .cx    (cx_r),
    .cy    (cy_r),
    .px    (px_r),
    .py    (py_r),
    .tol   (tol_r),
    .hit   (fan_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sph_pkg::ST_IDLE;
      cnt_r     <= '0;
      drain_r   <= 3'd0;
      hit_acc_r <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      drain_r   <= drain_nxt;
      hit_acc_r <= hit_acc_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    drain_nxt   = drain_r;
    hit_acc_nxt = hit_acc_r;
    ov_nxt      = 1'b0;
    ob_nxt      = ob_r;
    ctl         = '0;
    busy        = 1'b1;
    unique case (state_r)
      sph_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (acc && sph_pkg::op_t'(in_beat.operation) == sph_pkg::OP_TEST)
          state_nxt = sph_pkg::ST_DIST;
        else if (acc)
          state_nxt = sph_pkg::ST_DRAIN;
        drain_nxt = 3'd0;
      end
      sph_pkg::ST_DIST: state_nxt = sph_pkg::ST_RADIUS;
      sph_pkg::ST_RADIUS: begin
        if (d2_r >= 35'(outer_r)) begin
          ov_nxt = 1'b1;
          ob_nxt = '{hit: 1'b0, decided_by: sph_pkg::DEC_OUTER};
          state_nxt = sph_pkg::ST_IDLE;
        end else if (d2_r <= 35'(inner_r)) begin
          ov_nxt = 1'b1;
          ob_nxt = '{hit: 1'b1, decided_by: sph_pkg::DEC_INNER};
          state_nxt = sph_pkg::ST_IDLE;
        end else begin
          state_nxt = sph_pkg::ST_LOAD;
        end
      end
      sph_pkg::ST_LOAD: begin
        ctl.load    = 1'b1;
        cnt_nxt     = '0;
        hit_acc_nxt = 1'b0;
        state_nxt   = sph_pkg::ST_WALK;
      end
      sph_pkg::ST_WALK: begin
        ctl.shift   = 1'b1;
        hit_acc_nxt = hit_acc_r | fan_hit;
        cnt_nxt     = cnt_r + CW'(1);
        if (cnt_r == n_r - CW'(1)) begin
          state_nxt = sph_pkg::ST_DRAIN;
          drain_nxt = 3'd3;
        end
      end
      sph_pkg::ST_DRAIN: begin
        hit_acc_nxt = hit_acc_r | fan_hit;
        if (drain_r == 3'd0) begin
          state_nxt = sph_pkg::ST_IDLE;
        end else if (drain_r == 3'd1) begin
          ov_nxt    = 1'b1;
          ob_nxt    = '{hit: hit_acc_r | fan_hit, decided_by: sph_pkg::DEC_FAN};
          state_nxt = sph_pkg::ST_IDLE;
        end else begin
          drain_nxt = drain_r - 3'd1;
        end
      end
      default: state_nxt = sph_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_beat  = ob_r;

  `SPH_ASSERT_IMPL(a_busy_out, clk, rst_n, out_valid, state_r == sph_pkg::ST_IDLE)
  `SPH_ASSERT_NEXT(a_test_busy, clk, rst_n,
    acc && in_beat.operation == sph_pkg::OP_TEST, busy && !out_valid)
  `SPH_ASSERT_NEXT(a_one_strobe, clk, rst_n, out_valid, !out_valid)

endmodule
